>>> rtl/core/esf_pkg.sv
// esf_pkg: shared constants and types of the eight-digit seven-segment formatter.
// Used by the BCD pipeline, the digit scanner and the top level. No dependencies.
`timescale 1ns / 1ps

package esf_pkg;

	localparam int NUM_DIGITS = 8;
	localparam int IDX_W      = 3;
	localparam int CODE_W     = 5;
	localparam int VALUE_W    = 32;
	localparam int BCD_W      = 4 * NUM_DIGITS;

	// request mode codes; mode bit 1 selects hex
	localparam logic [1:0] MODE_DEC   = 2'd0;
	localparam logic [1:0] MODE_TIME  = 2'd1;
	localparam logic [1:0] MODE_HEX   = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, shown as hex

	// glyph code of the dash between time fields
	localparam logic [CODE_W-1:0] CODE_DASH = 5'd16;

	typedef logic [CODE_W-1:0] code_t;
	// element 0 is the leftmost position
	typedef code_t [NUM_DIGITS-1:0] codes_t;

	// last pipeline stage as seen by the scanner
	typedef struct packed {
		logic             vld;
		logic             dec;
		codes_t           codes;
		logic [BCD_W-1:0] bcd;
	} head_t;

endpackage

>>> rtl/core/esf_req_if.sv
// esf_req_if: request channel (valid/ready plus display request payload).
// No dependencies.
`timescale 1ns / 1ps

interface esf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] value;
	logic [6:0]  hours;
	logic [6:0]  minutes;
	logic [6:0]  seconds;

	modport source (output valid, output mode, output value, output hours,
		output minutes, output seconds, input ready);
	modport sink (input valid, input mode, input value, input hours,
		input minutes, input seconds, output ready);
endinterface

>>> rtl/core/esf_dig_if.sv
// esf_dig_if: digit channel (valid/ready plus one digit result per beat).
// No dependencies.
`timescale 1ns / 1ps

interface esf_dig_if;
	logic       valid;
	logic       ready;
	logic [2:0] digit_index;
	logic [7:0] digit_select;
	logic [6:0] segments;
	logic       last;

	modport source (output valid, output digit_index, output digit_select,
		output segments, output last, input ready);
	modport sink (input valid, input digit_index, input digit_select,
		input segments, input last, output ready);
endinterface

>>> rtl/core/esf_bcd_pipe.sv
// esf_bcd_pipe: request register chain with a double-dabble binary to BCD
// conversion, four bits per stage. Depends on esf_pkg and esf_req_if.
`timescale 1ns / 1ps

module esf_bcd_pipe (
	input  logic            clk,
	input  logic            arst_n,
	esf_req_if.sink         req,
	input  logic            load,
	output esf_pkg::head_t  head
);
	import esf_pkg::*;

	localparam int NUM_STAGES = VALUE_W / 4;
	localparam int BIN_W      = VALUE_W - 4;
	localparam int LAST       = NUM_STAGES - 1;

	typedef struct packed {
		logic             dec;
		codes_t           codes;
		logic [BCD_W-1:0] bcd;
	} stage_t;

	logic [NUM_STAGES-1:0] vld_s;
	stage_t                pipe_s [NUM_STAGES];
	logic [BIN_W-1:0]      bin_s [NUM_STAGES-1];
	stage_t                first_d;
	logic [7:0]            hh_d;
	logic [7:0]            mm_d;
	logic [7:0]            ss_d;
	logic                  adv;

	// four shift-add-3 steps; digits above the eighth drop out (value mod 1e8)
	function automatic logic [BCD_W-1:0] dd_step4(input logic [BCD_W-1:0] bcd_in,
			input logic [3:0] nib);
		logic [BCD_W-1:0] acc;
		acc = bcd_in;
		for (int s = 0; s < 4; s++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (acc[4*d +: 4] >= 4'd5) begin
					acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
				end
			end
			acc = {acc[BCD_W-2:0], nib[3-s]};
		end
		return acc;
	endfunction

	// clamp to 99, return {tens, units}
	function automatic logic [7:0] split99(input logic [6:0] x);
		logic [6:0] c;
		logic [3:0] t;
		logic [6:0] u;
		c = (x > 7'd99) ? 7'd99 : x;
		t = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (c >= 7'(10 * k)) begin
				t = 4'(k);
			end
		end
		u = c - 7'(7'(t) * 7'd10);
		return {t, u[3:0]};
	endfunction

	always_comb begin
		hh_d = split99(req.hours);
		mm_d = split99(req.minutes);
		ss_d = split99(req.seconds);
		first_d.dec = (req.mode == MODE_DEC);
		if (req.mode[1]) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				first_d.codes[i] = {1'b0, req.value[VALUE_W-1-4*i -: 4]};
			end
		end else begin
			// time layout; ignored downstream in decimal mode
			first_d.codes[0] = {1'b0, hh_d[7:4]};
			first_d.codes[1] = {1'b0, hh_d[3:0]};
			first_d.codes[2] = CODE_DASH;
			first_d.codes[3] = {1'b0, mm_d[7:4]};
			first_d.codes[4] = {1'b0, mm_d[3:0]};
			first_d.codes[5] = CODE_DASH;
			first_d.codes[6] = {1'b0, ss_d[7:4]};
			first_d.codes[7] = {1'b0, ss_d[3:0]};
		end
		first_d.bcd = dd_step4('0, req.value[VALUE_W-1 -: 4]);
	end

	// whole chain moves together; it stalls only when the head is held
	assign adv       = !vld_s[LAST] || load;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_STAGES-2:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[0] <= first_d;
			bin_s[0]  <= req.value[BIN_W-1:0];
			for (int i = 1; i < NUM_STAGES; i++) begin
				pipe_s[i].dec   <= pipe_s[i-1].dec;
				pipe_s[i].codes <= pipe_s[i-1].codes;
				pipe_s[i].bcd   <= dd_step4(pipe_s[i-1].bcd, bin_s[i-1][BIN_W-1 -: 4]);
			end
			for (int i = 1; i < NUM_STAGES - 1; i++) begin
				bin_s[i] <= {bin_s[i-1][BIN_W-5:0], 4'b0000};
			end
		end
	end

	assign head.vld   = vld_s[LAST];
	assign head.dec   = pipe_s[LAST].dec;
	assign head.codes = pipe_s[LAST].codes;
	assign head.bcd   = pipe_s[LAST].bcd;

`ifndef SYNTHESIS
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_s[0])
		else $error("accepted request did not enter the first stage");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST] && !load |=> vld_s[LAST] && $stable(pipe_s[LAST].bcd))
		else $error("held head stage changed");

	a_stage0_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && !adv |=> vld_s[0])
		else $error("stalled first stage lost its request");
`endif

endmodule

>>> rtl/core/esf_scan.sv
// esf_scan: digit scanner; loads eight glyphs from the pipeline head and
// sends one digit beat per cycle while ready. Depends on esf_pkg and esf_dig_if.
`timescale 1ns / 1ps

module esf_scan (
	input  logic           clk,
	input  logic           arst_n,
	input  esf_pkg::head_t head,
	output logic           load,
	esf_dig_if.source      dig
);
	import esf_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [6:0]       segs_q [NUM_DIGITS];
	code_t            code_d [NUM_DIGITS];
	logic             take;
	logic             at_end;

	// bit0 = segment a .. bit6 = segment g
	function automatic logic [6:0] seg_of(input code_t c);
		logic [6:0] p;
		case (c)
			5'd0:      p = 7'h3F;
			5'd1:      p = 7'h06;
			5'd2:      p = 7'h5B;
			5'd3:      p = 7'h4F;
			5'd4:      p = 7'h66;
			5'd5:      p = 7'h6D;
			5'd6:      p = 7'h7D;
			5'd7:      p = 7'h07;
			5'd8:      p = 7'h7F;
			5'd9:      p = 7'h6F;
			5'd10:     p = 7'h77;
			5'd11:     p = 7'h7C;
			5'd12:     p = 7'h39;
			5'd13:     p = 7'h5E;
			5'd14:     p = 7'h79;
			5'd15:     p = 7'h71;
			CODE_DASH: p = 7'h40;
			default:   p = 7'h00;
		endcase
		return p;
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			code_d[i] = head.dec ? {1'b0, head.bcd[BCD_W-1-4*i -: 4]} : head.codes[i];
		end
	end

	assign take   = dig.valid && dig.ready;
	assign at_end = (idx_q == IDX_W'(NUM_DIGITS - 1));
	assign load   = !busy_q || (take && at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= head.vld;
			idx_q  <= '0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				segs_q[i] <= seg_of(code_d[i]);
			end
		end
	end

	assign dig.valid        = busy_q;
	assign dig.digit_index  = idx_q;
	assign dig.digit_select = ~(8'b0000_0001 << idx_q);
	assign dig.segments     = segs_q[idx_q];
	assign dig.last         = at_end;

`ifndef SYNTHESIS
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		take && !at_end |=> dig.valid && (idx_q == $past(idx_q) + 1'b1))
		else $error("digit run broken or skipped a position");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		take && at_end && !head.vld |=> !dig.valid)
		else $error("digit beat shown with no request loaded");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid && !dig.ready |=> dig.valid && $stable(idx_q))
		else $error("scan position moved while stalled");
`endif

endmodule

>>> rtl/core/eight_digit_seven_segment_formatter_top.sv
// Top level of the eight-digit seven-segment formatter: BCD pipeline plus
// digit scanner. Depends on esf_pkg, esf_req_if, esf_dig_if, esf_bcd_pipe, esf_scan.
`timescale 1ns / 1ps
//
//   port  dir  beat carries                                   per request
//   req   in   mode, value, hours, minutes, seconds           1 beat
//   dig   out  digit_index, digit_select, segments, last      8 beats, leftmost first
//
// Flow: requests are paced by the single digit port (one digit beat per cycle
//   while dig.ready is high). The first digit follows the request beat through
//   the chain: the beat lands in stage 0, moves stage by stage to the head stage
//   (4 binary bits per stage), and is then loaded by the scanner.
// Reset: arst_n clears stage valid bits and the scanner; data registers are not reset.
// Stalls: the conversion chain advances as a whole whenever its head is empty or
//   the scanner is taking it, so new requests keep entering while a run is held
//   until the head stage fills; a full head waiting on the scanner drops req.ready.
//
// Decimal mode runs a double-dabble conversion keeping only eight BCD digits,
// which yields value mod 100000000 directly. Time fields are clamped to 99 and
// split at entry; hex nibbles are picked straight from value.

module eight_digit_seven_segment_formatter_top (
	input  logic      clk,
	input  logic      arst_n,
	esf_req_if.sink   req,
	esf_dig_if.source dig
);
	import esf_pkg::*;

	head_t head;   // last conversion stage
	logic  load;   // scanner takes the head this cycle

	esf_bcd_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.load   (load),
		.head   (head)
	);

	esf_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.load   (load),
		.dig    (dig)
	);

endmodule
